/* hw/rtl/tqps_pkg.sv */
package tqps_pkg;

    // Default storage depth of each class queue
    localparam int QUEUE_DEPTH_DEFAULT = 16;

    // Time arithmetic is modulo 2^TIME_BITS; fields are 16 bits wide
    localparam int TIME_BITS = 16;
    localparam int FIELD_W   = 16;
    localparam int TIME_W    = (TIME_BITS < FIELD_W) ? TIME_BITS : FIELD_W;

    localparam int LIMIT_W   = 5;
    localparam int SIZE_W    = 5;
    localparam int CNT_W     = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    // Input action codes
    typedef enum logic [1:0] {
        ACT_HIGH_REQ = 2'd0,
        ACT_LOW_REQ  = 2'd1,
        ACT_TICK     = 2'd2,
        ACT_NOP      = 2'd3
    } action_t;

    // Activity codes reported on the result
    localparam logic [1:0] ACTV_IDLE = 2'd0;
    localparam logic [1:0] ACTV_HIGH = 2'd1;
    localparam logic [1:0] ACTV_LOW  = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [FIELD_W-1:0] flight_tag;
        logic [FIELD_W-1:0] arrival_time;
        logic [FIELD_W-1:0] current_time;
    } in_item_t;

    typedef struct packed {
        logic               refused;
        logic [1:0]         activity;
        logic [FIELD_W-1:0] served_tag;
        logic [FIELD_W-1:0] wait_time;
        logic [SIZE_W-1:0]  high_queue_size;
        logic [SIZE_W-1:0]  low_queue_size;
        logic [CNT_W-1:0]   high_served_count;
        logic [CNT_W-1:0]   low_served_count;
        logic [CNT_W-1:0]   idle_ticks;
        logic [CNT_W-1:0]   high_wait_sum;
        logic [CNT_W-1:0]   low_wait_sum;
    } out_item_t;

    // One queue entry
    typedef struct packed {
        logic [FIELD_W-1:0] tag;
        logic [FIELD_W-1:0] arrival;
    } entry_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_READ   = 2'd1,
        ST_UPDATE = 2'd2
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic read;
        logic commit;
    } cmd_t;

    // Add with saturation at all ones
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

/* hw/rtl/two_queue_priority_server.sv */
// An accepted transaction passes through the controller sequence (capture, registered head
// read of the queue memories, update and commit) into the output register; the commit waits
// while the output is stalled, and no new transaction is taken until the sequence ends.
// A new transaction is accepted while a finished result waits in the output register.
// Reset (rst_n, async, active low): both queues empty, all counters zero, limit register 16.
module two_queue_priority_server #(
    parameter int QUEUE_DEPTH = tqps_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  tqps_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output tqps_pkg::out_item_t           out_data,
    input  logic                          cfg_write_en,
    input  logic [tqps_pkg::LIMIT_W-1:0]  cfg_write_data
);

    tqps_pkg::cmd_t cmd;

    tqps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    tqps_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .in_data        (in_data),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .out_data       (out_data)
    );

endmodule

/* hw/rtl/tqps_fifo.sv */
module tqps_fifo #(
    parameter int QUEUE_DEPTH = tqps_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [tqps_pkg::LIMIT_W-1:0]           limit,
    input  logic                                   push,
    input  logic                                   pop,
    input  logic                                   rd_en,
    input  tqps_pkg::entry_t                       wr_data,
    output tqps_pkg::entry_t                       rd_data,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]       count,
    output logic                                   full
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = IW + 1;
    localparam int LW = (CW > tqps_pkg::LIMIT_W) ? CW : tqps_pkg::LIMIT_W;

    tqps_pkg::entry_t mem [QUEUE_DEPTH];
    tqps_pkg::entry_t rd_data_reg;

    logic [IW-1:0] head_reg;
    logic [IW-1:0] head_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [SW-1:0] slot_sum;
    logic [SW-1:0] tail;

    // Compute the tail slot, wrapping past the end of the store
    always_comb
    begin
        slot_sum = SW'(head_reg) + SW'(count_reg);
        if (slot_sum >= SW'(QUEUE_DEPTH))
        begin
            tail = slot_sum - SW'(QUEUE_DEPTH);
        end
        else
        begin
            tail = slot_sum;
        end
    end

    // Refuse at the programmed limit or at the physical depth
    assign full = (LW'(count_reg) >= LW'(limit)) || (count_reg == CW'(QUEUE_DEPTH));

    // Advance head on pop, adjust occupancy
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (pop)
        begin
            head_next  = (head_reg == IW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + IW'(1);
            count_next = count_reg - CW'(1);
        end
        else if (push)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Write at the tail, registered read at the head
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail[IW-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    assign rd_data = rd_data_reg;
    assign count   = count_reg;

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (count_reg != '0) && (count_reg <= CW'(QUEUE_DEPTH)))
        else $error("queue occupancy out of range after push");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0) && !push)
        else $error("pop from empty queue or pop with push");

endmodule

/* hw/rtl/tqps_datapath.sv */
module tqps_datapath #(
    parameter int QUEUE_DEPTH = tqps_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tqps_pkg::cmd_t                cmd,
    input  tqps_pkg::in_item_t            in_data,
    input  logic                          cfg_write_en,
    input  logic [tqps_pkg::LIMIT_W-1:0]  cfg_write_data,
    output tqps_pkg::out_item_t           out_data
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W = tqps_pkg::CNT_W;

    tqps_pkg::in_item_t              item_reg;
    tqps_pkg::out_item_t             result_reg;
    tqps_pkg::out_item_t             result_next;
    logic [tqps_pkg::LIMIT_W-1:0]    limit_reg;

    logic [CNT_W-1:0] high_served_reg, high_served_next;
    logic [CNT_W-1:0] low_served_reg, low_served_next;
    logic [CNT_W-1:0] idle_total_reg, idle_total_next;
    logic [CNT_W-1:0] high_wait_reg, high_wait_next;
    logic [CNT_W-1:0] low_wait_reg, low_wait_next;

    tqps_pkg::entry_t wr_entry;
    tqps_pkg::entry_t high_rd;
    tqps_pkg::entry_t low_rd;
    tqps_pkg::entry_t served;
    logic [CW-1:0]    high_count;
    logic [CW-1:0]    low_count;
    logic [CW-1:0]    high_size;
    logic [CW-1:0]    low_size;
    logic [CW+4:0]    high_size_ext;
    logic [CW+4:0]    low_size_ext;
    logic             high_full;
    logic             low_full;
    logic             is_high_req;
    logic             is_low_req;
    logic             is_tick;
    logic             serve_high;
    logic             serve_low;
    logic             serve_none;
    logic             push_high;
    logic             push_low;
    logic             pop_high;
    logic             pop_low;
    logic [tqps_pkg::TIME_W-1:0]  wait_diff;
    logic [tqps_pkg::FIELD_W-1:0] wait_val;

    // Hold the accepted transaction
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_data;
        end
    end

    // Queue limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= tqps_pkg::LIMIT_RESET;
        end
        else if (cfg_write_en)
        begin
            limit_reg <= cfg_write_data;
        end
    end

    // Decode the held action
    assign is_high_req = (item_reg.action == tqps_pkg::ACT_HIGH_REQ);
    assign is_low_req  = (item_reg.action == tqps_pkg::ACT_LOW_REQ);
    assign is_tick     = (item_reg.action == tqps_pkg::ACT_TICK);

    // Strict priority: high class first
    always_comb
    begin
        serve_high = 1'b0;
        serve_low  = 1'b0;
        serve_none = 1'b0;
        priority if (!is_tick)
        begin
            serve_none = 1'b0;
        end
        else if (high_count != '0)
        begin
            serve_high = 1'b1;
        end
        else if (low_count != '0)
        begin
            serve_low = 1'b1;
        end
        else
        begin
            serve_none = 1'b1;
        end
    end

    assign push_high = cmd.commit && is_high_req && !high_full;
    assign push_low  = cmd.commit && is_low_req && !low_full;
    assign pop_high  = cmd.commit && serve_high;
    assign pop_low   = cmd.commit && serve_low;

    assign wr_entry.tag     = item_reg.flight_tag;
    assign wr_entry.arrival = item_reg.arrival_time;

    tqps_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_high_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .limit   (limit_reg),
        .push    (push_high),
        .pop     (pop_high),
        .rd_en   (cmd.read),
        .wr_data (wr_entry),
        .rd_data (high_rd),
        .count   (high_count),
        .full    (high_full)
    );

    tqps_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_low_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .limit   (limit_reg),
        .push    (push_low),
        .pop     (pop_low),
        .rd_en   (cmd.read),
        .wr_data (wr_entry),
        .rd_data (low_rd),
        .count   (low_count),
        .full    (low_full)
    );

    // Wait of the served entry, modulo the time width
    assign served    = serve_high ? high_rd : low_rd;
    assign wait_diff = item_reg.current_time[tqps_pkg::TIME_W-1:0]
                     - served.arrival[tqps_pkg::TIME_W-1:0];
    assign wait_val  = tqps_pkg::FIELD_W'(wait_diff);

    // Update the saturating counters
    always_comb
    begin
        high_served_next = high_served_reg;
        low_served_next  = low_served_reg;
        idle_total_next  = idle_total_reg;
        high_wait_next   = high_wait_reg;
        low_wait_next    = low_wait_reg;
        if (serve_high)
        begin
            high_served_next = tqps_pkg::sat_add(high_served_reg, CNT_W'(1));
            high_wait_next   = tqps_pkg::sat_add(high_wait_reg, CNT_W'(wait_val));
        end
        if (serve_low)
        begin
            low_served_next = tqps_pkg::sat_add(low_served_reg, CNT_W'(1));
            low_wait_next   = tqps_pkg::sat_add(low_wait_reg, CNT_W'(wait_val));
        end
        if (serve_none)
        begin
            idle_total_next = tqps_pkg::sat_add(idle_total_reg, CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_served_reg <= '0;
            low_served_reg  <= '0;
            idle_total_reg  <= '0;
            high_wait_reg   <= '0;
            low_wait_reg    <= '0;
        end
        else if (cmd.commit)
        begin
            high_served_reg <= high_served_next;
            low_served_reg  <= low_served_next;
            idle_total_reg  <= idle_total_next;
            high_wait_reg   <= high_wait_next;
            low_wait_reg    <= low_wait_next;
        end
    end

    // Queue sizes after this transaction
    assign high_size     = high_count + CW'(push_high) - CW'(pop_high);
    assign low_size      = low_count + CW'(push_low) - CW'(pop_low);
    assign high_size_ext = (CW + 5)'(high_size);
    assign low_size_ext  = (CW + 5)'(low_size);

    // Assemble the result
    always_comb
    begin
        result_next.refused           = (is_high_req && high_full) || (is_low_req && low_full);
        result_next.activity          = serve_high ? tqps_pkg::ACTV_HIGH :
                                        serve_low  ? tqps_pkg::ACTV_LOW  : tqps_pkg::ACTV_IDLE;
        result_next.served_tag        = (serve_high || serve_low) ? served.tag : '0;
        result_next.wait_time         = (serve_high || serve_low) ? wait_val : '0;
        result_next.high_queue_size   = high_size_ext[tqps_pkg::SIZE_W-1:0];
        result_next.low_queue_size    = low_size_ext[tqps_pkg::SIZE_W-1:0];
        result_next.high_served_count = high_served_next;
        result_next.low_served_count  = low_served_next;
        result_next.idle_ticks        = idle_total_next;
        result_next.high_wait_sum     = high_wait_next;
        result_next.low_wait_sum      = low_wait_next;
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            result_reg <= result_next;
        end
    end

    assign out_data = result_reg;

endmodule

/* hw/rtl/tqps_ctrl.sv */
module tqps_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    output tqps_pkg::cmd_t  cmd
);

    tqps_pkg::state_t state_reg;
    tqps_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_busy;

    assign out_busy = out_valid_reg && out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tqps_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tqps_pkg::ST_READ;
                end
            end
            tqps_pkg::ST_READ:
            begin
                state_next = tqps_pkg::ST_UPDATE;
            end
            tqps_pkg::ST_UPDATE:
            begin
                if (!out_busy)
                begin
                    state_next = tqps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tqps_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            tqps_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            tqps_pkg::ST_READ:
            begin
                cmd.read = 1'b1;
            end
            tqps_pkg::ST_UPDATE:
            begin
                cmd.commit = !out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Output valid: set on commit, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tqps_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_accept_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == tqps_pkg::ST_READ))
        else $error("accepted transaction did not start a read");

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_valid_reg && out_stall) && out_valid_reg && out_stall |-> !cmd.commit)
        else $error("result overwritten while stalled");

endmodule

/* sim/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIELD_W = tqps_pkg::FIELD_W;
    localparam int TIME_W  = tqps_pkg::TIME_W;
    localparam int LIMIT_W = tqps_pkg::LIMIT_W;
    localparam int SIZE_W  = tqps_pkg::SIZE_W;
    localparam int CNT_W   = tqps_pkg::CNT_W;

    localparam int QUIET_LIMIT = 3000;   // cycles with no transaction before giving up
    localparam int HOLD_AT     = 360;    // results seen before the long receiver hold-off
    localparam int HOLD_CYCLES = 300;
    localparam logic [FIELD_W-1:0] TIME_MASK =
        (TIME_W >= FIELD_W) ? {FIELD_W{1'b1}} : FIELD_W'((1 << TIME_W) - 1);

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    tqps_pkg::in_item_t   in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    tqps_pkg::out_item_t  out_data;
    logic                 cfg_write_en = 1'b0;
    logic [LIMIT_W-1:0]   cfg_write_data = '0;

    // Items waiting to be offered, and results predicted but not yet seen
    tqps_pkg::in_item_t   backlog[$];
    tqps_pkg::out_item_t  outcome_q[$];

    // Predicted server state
    tqps_pkg::entry_t     high_line[$];
    tqps_pkg::entry_t     low_line[$];
    logic [LIMIT_W-1:0]   limit_m = tqps_pkg::LIMIT_RESET;
    logic [CNT_W-1:0]     high_served_m = '0;
    logic [CNT_W-1:0]     low_served_m = '0;
    logic [CNT_W-1:0]     idle_m = '0;
    logic [CNT_W-1:0]     high_wait_m = '0;
    logic [CNT_W-1:0]     low_wait_m = '0;

    int                   fail_count = 0;
    int                   gap_left = 0;
    int                   stall_left = 0;
    int                   free_left = 0;
    int                   results_seen = 0;
    bit                   hold_done = 1'b0;
    int                   quiet_cycles = 0;
    int                   pick;

    two_queue_priority_server u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always #1 clk = ~clk;

    function automatic logic [CNT_W-1:0] add_clamped(logic [CNT_W-1:0] a,
                                                     logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    // Apply one transaction to the predicted server and queue its result
    function automatic void predict_outcome(tqps_pkg::in_item_t it);
        tqps_pkg::out_item_t o;
        tqps_pkg::entry_t    e;
        int                  cap;
        logic [FIELD_W-1:0]  w;
        o = '0;
        cap = (limit_m > tqps_pkg::QUEUE_DEPTH_DEFAULT) ? tqps_pkg::QUEUE_DEPTH_DEFAULT
                                                         : int'(limit_m);
        e.tag = it.flight_tag;
        e.arrival = it.arrival_time;
        case (it.action)
            tqps_pkg::ACT_HIGH_REQ:
            begin
                if (high_line.size() < cap)
                    high_line.push_back(e);
                else
                    o.refused = 1'b1;
            end
            tqps_pkg::ACT_LOW_REQ:
            begin
                if (low_line.size() < cap)
                    low_line.push_back(e);
                else
                    o.refused = 1'b1;
            end
            tqps_pkg::ACT_TICK:
            begin
                // strict priority: high class first, then low, else idle
                if (high_line.size() != 0)
                begin
                    e = high_line.pop_front();
                    w = (it.current_time - e.arrival) & TIME_MASK;
                    high_wait_m = add_clamped(high_wait_m, CNT_W'(w));
                    high_served_m = add_clamped(high_served_m, CNT_W'(1));
                    o.activity = tqps_pkg::ACTV_HIGH;
                    o.served_tag = e.tag;
                    o.wait_time = w;
                end
                else if (low_line.size() != 0)
                begin
                    e = low_line.pop_front();
                    w = (it.current_time - e.arrival) & TIME_MASK;
                    low_wait_m = add_clamped(low_wait_m, CNT_W'(w));
                    low_served_m = add_clamped(low_served_m, CNT_W'(1));
                    o.activity = tqps_pkg::ACTV_LOW;
                    o.served_tag = e.tag;
                    o.wait_time = w;
                end
                else
                begin
                    idle_m = add_clamped(idle_m, CNT_W'(1));
                    o.activity = tqps_pkg::ACTV_IDLE;
                end
            end
            default:
            begin
            end
        endcase
        o.high_queue_size = SIZE_W'(high_line.size());
        o.low_queue_size = SIZE_W'(low_line.size());
        o.high_served_count = high_served_m;
        o.low_served_count = low_served_m;
        o.idle_ticks = idle_m;
        o.high_wait_sum = high_wait_m;
        o.low_wait_sum = low_wait_m;
        outcome_q.push_back(o);
    endfunction

    task automatic compare_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_outcome(tqps_pkg::out_item_t got);
        tqps_pkg::out_item_t want;
        if (outcome_q.size() == 0)
        begin
            $error("result transaction arrived with none outstanding");
            fail_count++;
        end
        else
        begin
            want = outcome_q.pop_front();
            compare_field("refused", CNT_W'(want.refused), CNT_W'(got.refused));
            compare_field("activity", CNT_W'(want.activity), CNT_W'(got.activity));
            compare_field("served_tag", CNT_W'(want.served_tag), CNT_W'(got.served_tag));
            compare_field("wait_time", CNT_W'(want.wait_time), CNT_W'(got.wait_time));
            compare_field("high_queue_size", CNT_W'(want.high_queue_size),
                          CNT_W'(got.high_queue_size));
            compare_field("low_queue_size", CNT_W'(want.low_queue_size),
                          CNT_W'(got.low_queue_size));
            compare_field("high_served_count", want.high_served_count, got.high_served_count);
            compare_field("low_served_count", want.low_served_count, got.low_served_count);
            compare_field("idle_ticks", want.idle_ticks, got.idle_ticks);
            compare_field("high_wait_sum", want.high_wait_sum, got.high_wait_sum);
            compare_field("low_wait_sum", want.low_wait_sum, got.low_wait_sum);
        end
    endtask

    // Driver: offer backlog items with random gaps, hold while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_outcome(in_data);
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (backlog.size() > 0)
                begin
                    in_data <= backlog.pop_front();
                    in_valid <= 1'b1;
                    pick = $urandom_range(99);
                    if (pick < 60)
                        gap_left = 0;
                    else if (pick < 90)
                        gap_left = $urandom_range(1, 3);
                    else if (pick < 98)
                        gap_left = $urandom_range(4, 10);
                    else
                        gap_left = $urandom_range(20, 40);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result transaction and stall the output at random
    always @(posedge clk or negedge rst_n)
    begin : monitor
        int r;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                check_outcome(out_data);
                results_seen++;
            end
            // one long hold-off so the block backs up and stalls its input
            if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                stall_left = HOLD_CYCLES;
                free_left = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (free_left > 0)
            begin
                free_left--;
                out_stall <= 1'b0;
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 55)
                begin
                    free_left = $urandom_range(0, 30);
                    out_stall <= 1'b0;
                end
                else if (r < 95)
                begin
                    stall_left = $urandom_range(0, 2);
                    out_stall <= 1'b1;
                end
                else
                begin
                    stall_left = $urandom_range(10, 40);
                    out_stall <= 1'b1;
                end
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    function automatic tqps_pkg::in_item_t make_item(tqps_pkg::action_t a,
                                                     logic [FIELD_W-1:0] tag,
                                                     logic [FIELD_W-1:0] arr,
                                                     logic [FIELD_W-1:0] cur);
        tqps_pkg::in_item_t it;
        it.action = a;
        it.flight_tag = tag;
        it.arrival_time = arr;
        it.current_time = cur;
        return it;
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (backlog.size() != 0 || in_valid || outcome_q.size() != 0);
    endtask

    task automatic set_limit(logic [LIMIT_W-1:0] v);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        limit_m = v;
    endtask

    // Queue random bursts, each with its own request and class mix, that fill and drain the two classes
    task automatic queue_random(int n);
        int                 burst;
        int                 req_pct;
        int                 high_pct;
        int                 r;
        tqps_pkg::in_item_t it;
        @(negedge clk);
        while (n > 0)
        begin
            burst = $urandom_range(10, 60);
            if (burst > n)
                burst = n;
            r = $urandom_range(2);
            req_pct = (r == 0) ? 85 : (r == 1) ? 30 : 55;
            high_pct = $urandom_range(15, 85);
            repeat (burst)
            begin
                it.flight_tag = FIELD_W'($urandom);
                it.arrival_time = FIELD_W'($urandom);
                it.current_time = FIELD_W'($urandom);
                r = $urandom_range(99);
                if (r < 3)
                    it.action = tqps_pkg::ACT_NOP;
                else if (r < req_pct)
                    it.action = ($urandom_range(99) < high_pct) ? tqps_pkg::ACT_HIGH_REQ
                                                                : tqps_pkg::ACT_LOW_REQ;
                else
                    it.action = tqps_pkg::ACT_TICK;
                backlog.push_back(it);
            end
            n -= burst;
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty queues, field extremes, priority order, wait wraparound
        @(negedge clk);
        backlog.push_back(make_item(tqps_pkg::ACT_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        backlog.push_back(make_item(tqps_pkg::ACT_TICK, 16'h0000, 16'h0000, 16'h0000));
        backlog.push_back(make_item(tqps_pkg::ACT_LOW_REQ, 16'hA5A5, 16'h8000, 16'h0000));
        backlog.push_back(make_item(tqps_pkg::ACT_HIGH_REQ, 16'h0000, 16'h0000, 16'h0000));
        backlog.push_back(make_item(tqps_pkg::ACT_HIGH_REQ, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        backlog.push_back(make_item(tqps_pkg::ACT_NOP, 16'h0000, 16'h0000, 16'h0000));
        backlog.push_back(make_item(tqps_pkg::ACT_TICK, 16'h0000, 16'h0000, 16'hFFFF));
        backlog.push_back(make_item(tqps_pkg::ACT_TICK, 16'hFFFF, 16'hFFFF, 16'h0000));
        backlog.push_back(make_item(tqps_pkg::ACT_TICK, 16'h0000, 16'h0000, 16'h8000));
        backlog.push_back(make_item(tqps_pkg::ACT_TICK, 16'h5A5A, 16'h5A5A, 16'h1234));
        queue_random(150);

        // Limit of zero refuses every request
        set_limit(5'd0);
        @(negedge clk);
        backlog.push_back(make_item(tqps_pkg::ACT_HIGH_REQ, 16'h1111, 16'h2222, 16'h3333));
        backlog.push_back(make_item(tqps_pkg::ACT_LOW_REQ, 16'h4444, 16'h5555, 16'h6666));
        backlog.push_back(make_item(tqps_pkg::ACT_TICK, 16'h7777, 16'h8888, 16'h9999));
        queue_random(40);

        set_limit(5'd1);
        queue_random(100);

        // Limit above the queue depth acts as the depth
        set_limit(5'd31);
        queue_random(150);

        set_limit(LIMIT_W'($urandom_range(2, 15)));
        queue_random(150);

        set_limit(5'd16);
        queue_random(110);

        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
